>>> rtl/pgst_pkg.sv
// pgst_pkg: shared types and constants for the position geofence stim trigger
// holds the command, table entry, result and register types used by front, back and top
// no dependencies
package pgst_pkg;

    // coordinate and counter widths
    localparam int COORD_W      = 16;
    localparam int IN_TDATA_W   = 56;
    localparam int IN_TUSER_W   = 2;
    localparam int OUT_TDATA_W  = 8;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 16;

    localparam logic [15:0] ELAPSED_MAX  = 16'hFFFF;
    localparam logic [15:0] PERIOD_RESET = 16'd100;

    // input item kinds
    typedef enum logic [1:0] {
        OP_POS    = 2'd0,
        OP_TICK   = 2'd1,
        OP_CIRCLE = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_ENABLE  = 2'd0,
        CFG_CHANNEL = 2'd1,
        CFG_PERIOD  = 2'd2
    } cfg_reg_t;

    // classified command passed from front to back
    typedef struct packed {
        op_t         op;
        logic        pos_ok;
        logic        wr_ok;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] radius;
        logic [2:0]  circle_index;
        logic        circle_valid;
    } cmd_t;

    // one circle table entry
    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] radius;
    } entry_t;

    // register settings seen by the back end
    typedef struct packed {
        logic        enable;
        logic [1:0]  out_channel;
        logic [15:0] period_ms;
    } cfg_t;

    // result word, trigger in bit 0
    typedef struct packed {
        logic        pad;
        logic [2:0]  match_index;
        logic        inside_res;
        logic [1:0]  trigger_channel;
        logic        trigger;
    } out_t;

endpackage

>>> rtl/pgst_front.sv
// pgst_front: input side, unpacks and classifies items and buffers them in a two-entry queue
// depends on pgst_pkg
module pgst_front #(
    parameter int NUM_CIRCLES = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // coord_x [15:0], coord_y [31:16], circle_index [34:32], radius [50:35],
    // circle_valid [51], zero [55:52]
    input  logic [pgst_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // opcode [1:0]
    input  logic [pgst_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                             q_valid,
    output pgst_pkg::cmd_t                   q_cmd,
    input  logic                             q_pop
);
    import pgst_pkg::*;

    localparam logic [6:0] NUM_ENTRIES = 7'(NUM_CIRCLES);

    cmd_t       cmd_in;
    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;

    // unpack and classify the incoming item
    always_comb
    begin
        cmd_in.op           = op_t'(s_axis_tuser);
        cmd_in.x            = s_axis_tdata[15:0];
        cmd_in.y            = s_axis_tdata[31:16];
        cmd_in.circle_index = s_axis_tdata[34:32];
        cmd_in.radius       = s_axis_tdata[50:35];
        cmd_in.circle_valid = s_axis_tdata[51];
        cmd_in.pos_ok       = 1'b0;
        cmd_in.wr_ok        = 1'b0;
        unique case (cmd_in.op) inside
            OP_POS:
            begin
                cmd_in.pos_ok = (cmd_in.x != '0) && (cmd_in.y != '0);
            end
            OP_CIRCLE:
            begin
                cmd_in.wr_ok = {4'd0, cmd_in.circle_index} < NUM_ENTRIES;
            end
            OP_TICK, OP_NONE:
            begin
                cmd_in.pos_ok = 1'b0;
            end
            default:
            begin
                cmd_in.wr_ok = 1'b0;
            end
        endcase
    end

    assign s_axis_tready = (count_reg != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready;
    assign q_valid       = (count_reg != 2'd0);
    assign q_cmd         = slot_reg[rd_ptr_reg];

    // queue payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= cmd_in;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !q_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (!push && q_pop)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> count_reg == $past(count_reg) + 2'd1)
        else $error("transfer in did not grow the queue");
`endif

endmodule

>>> rtl/pgst_back.sv
// pgst_back: executes queued commands, scans the circle table and produces one result per item
// depends on pgst_pkg
module pgst_back #(
    parameter int NUM_CIRCLES  = 8,
    parameter int NUM_CHANNELS = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             q_valid,
    input  pgst_pkg::cmd_t                   q_cmd,
    output logic                             q_pop,
    input  pgst_pkg::cfg_t                   cfg,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [pgst_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import pgst_pkg::*;

    localparam int IDX_W = (NUM_CIRCLES > 1) ? $clog2(NUM_CIRCLES) : 1;
    localparam int CNT_W = $clog2(NUM_CIRCLES + 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(NUM_CIRCLES);
    localparam logic [2:0]       CHAN_NUM = 3'(NUM_CHANNELS);
    localparam logic [1:0]       CHAN_MAX = 2'(NUM_CHANNELS - 1);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SCAN   = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    cmd_t               cmd_reg;
    logic [15:0]        px_reg, py_reg;
    logic               known_reg;
    logic [NUM_CIRCLES-1:0] valid_reg;
    entry_t             mem [NUM_CIRCLES];
    entry_t             rd_reg;
    logic [CNT_W-1:0]   issue_cnt_reg;

    logic               a_vld_reg, a_en_reg;
    logic [IDX_W-1:0]   a_idx_reg;
    logic               b_vld_reg, b_en_reg;
    logic [IDX_W-1:0]   b_idx_reg;
    logic [15:0]        b_dx_reg, b_dy_reg, b_r_reg;
    logic               c_vld_reg, c_en_reg;
    logic [IDX_W-1:0]   c_idx_reg;
    logic [31:0]        c_dx2_reg, c_dy2_reg, c_r2_reg;
    logic               hit_reg;
    logic [IDX_W-1:0]   which_reg;

    logic [15:0]        elapsed_reg, elapsed_next, elapsed_inc;
    logic               m_valid_reg;
    out_t               out_reg, out_next;

    logic               take, issue, scan_done, out_free, finish;
    logic               mem_we, tbl_wr;
    logic [IDX_W-1:0]   wr_addr, rd_addr;
    logic [32:0]        dist_sq;
    logic               in_circle;
    logic               point_in, fire;
    logic [1:0]         chan;

    // handshake and sequencing terms
    assign take      = (state_reg == S_IDLE) && q_valid;
    assign q_pop     = take;
    assign issue     = (state_reg == S_SCAN) && (issue_cnt_reg != CNT_END);
    assign scan_done = (issue_cnt_reg == CNT_END) && !a_vld_reg && !b_vld_reg && !c_vld_reg;
    assign out_free  = !m_valid_reg || m_axis_tready;
    assign finish    = (state_reg == S_FINISH) && out_free;
    assign tbl_wr    = take && (q_cmd.op == OP_CIRCLE) && q_cmd.wr_ok;
    assign mem_we    = tbl_wr && q_cmd.circle_valid;
    assign wr_addr   = IDX_W'(q_cmd.circle_index);
    assign rd_addr   = issue_cnt_reg[IDX_W-1:0];

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // circle table, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= '{x: q_cmd.x, y: q_cmd.y, radius: q_cmd.radius};
        end
        rd_reg <= mem[rd_addr];
    end

    // scan pipeline payload: distance terms then squares
    always_ff @(posedge clk)
    begin
        a_idx_reg <= rd_addr;
        b_idx_reg <= a_idx_reg;
        b_dx_reg  <= (px_reg >= rd_reg.x) ? px_reg - rd_reg.x : rd_reg.x - px_reg;
        b_dy_reg  <= (py_reg >= rd_reg.y) ? py_reg - rd_reg.y : rd_reg.y - py_reg;
        b_r_reg   <= rd_reg.radius;
        c_idx_reg <= b_idx_reg;
        c_dx2_reg <= {16'd0, b_dx_reg} * {16'd0, b_dx_reg};
        c_dy2_reg <= {16'd0, b_dy_reg} * {16'd0, b_dy_reg};
        c_r2_reg  <= {16'd0, b_r_reg} * {16'd0, b_r_reg};
    end

    // final compare of the scan
    assign dist_sq   = {1'b0, c_dx2_reg} + {1'b0, c_dy2_reg};
    assign in_circle = c_vld_reg && c_en_reg && (dist_sq <= {1'b0, c_r2_reg});

    // tick handling and result word
    always_comb
    begin
        elapsed_inc = (elapsed_reg != ELAPSED_MAX) ? elapsed_reg + 16'd1 : elapsed_reg;
        point_in    = hit_reg && known_reg;
        fire        = (cmd_reg.op == OP_TICK) && cfg.enable && point_in
                      && (elapsed_inc >= cfg.period_ms);
        chan        = ({1'b0, cfg.out_channel} >= CHAN_NUM) ? CHAN_MAX : cfg.out_channel;
        elapsed_next = elapsed_reg;
        if (finish && (cmd_reg.op == OP_TICK))
        begin
            elapsed_next = fire ? 16'd0 : elapsed_inc;
        end
        out_next.pad             = 1'b0;
        out_next.match_index     = point_in ? 3'(which_reg) : 3'd0;
        out_next.inside_res      = point_in;
        out_next.trigger_channel = chan;
        out_next.trigger         = fire;
    end

    // command, point and result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            cmd_reg <= q_cmd;
            if ((q_cmd.op == OP_POS) && q_cmd.pos_ok)
            begin
                px_reg <= q_cmd.x;
                py_reg <= q_cmd.y;
            end
        end
        if (finish)
        begin
            out_reg <= out_next;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            known_reg     <= 1'b0;
            valid_reg     <= '0;
            issue_cnt_reg <= '0;
            a_vld_reg     <= 1'b0;
            a_en_reg      <= 1'b0;
            b_vld_reg     <= 1'b0;
            b_en_reg      <= 1'b0;
            c_vld_reg     <= 1'b0;
            c_en_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            which_reg     <= '0;
            elapsed_reg   <= ELAPSED_MAX;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            elapsed_reg <= elapsed_next;
            a_vld_reg   <= issue;
            a_en_reg    <= issue && valid_reg[rd_addr];
            b_vld_reg   <= a_vld_reg;
            b_en_reg    <= a_en_reg;
            c_vld_reg   <= b_vld_reg;
            c_en_reg    <= b_en_reg;
            if (take)
            begin
                issue_cnt_reg <= '0;
                hit_reg       <= 1'b0;
                which_reg     <= '0;
                if ((q_cmd.op == OP_POS) && q_cmd.pos_ok)
                begin
                    known_reg <= 1'b1;
                end
                if (tbl_wr)
                begin
                    valid_reg[wr_addr] <= q_cmd.circle_valid;
                end
            end
            else
            begin
                if (issue)
                begin
                    issue_cnt_reg <= issue_cnt_reg + CNT_W'(1);
                end
                // circles arrive in index order, so the last match wins
                if (in_circle)
                begin
                    hit_reg   <= 1'b1;
                    which_reg <= c_idx_reg;
                end
            end
            if (finish)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = out_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        issue_cnt_reg <= CNT_END)
        else $error("scan counter past table end");

    a_trig_inside: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> (!out_reg.trigger || out_reg.inside_res))
        else $error("trigger without a containing circle");

    a_load_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(state_reg == S_FINISH))
        else $error("result loaded outside finish");

    a_hit_scan: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(hit_reg) |-> $past(state_reg == S_SCAN))
        else $error("match flag set outside scan");
`endif

endmodule

>>> rtl/position_geofence_stim_trigger_unit.sv
// position_geofence_stim_trigger_unit: top level with register file, front queue and back end
// depends on pgst_pkg, pgst_front and pgst_back
//
// Takes position samples, millisecond ticks and circle table writes on one input stream
// and returns one result transfer per item: trigger flag, channel, whether the stored point
// lies in a valid circle, and the highest matching circle index. Each item occupies the back
// end while it applies the update, makes one table read per circle through a four-stage
// distance and compare pipeline, and loads the result register. A two-entry queue ahead of
// the back end takes items while a scan runs, and a result may wait in its output register
// while the next item is processed. Configuration writes are taken every cycle.
module position_geofence_stim_trigger_unit #(
    parameter int NUM_CIRCLES  = 8,
    parameter int NUM_CHANNELS = 4
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // coord_x [15:0], coord_y [31:16], circle_index [34:32], radius [50:35],
    // circle_valid [51], zero [55:52]
    input  logic [pgst_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // opcode [1:0]
    input  logic [pgst_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // trigger [0], trigger_channel [2:1], inside_res [3], match_index [6:4], zero [7]
    output logic [pgst_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pgst_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [pgst_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import pgst_pkg::*;

    cfg_t cfg_reg;
    logic q_valid;
    cmd_t q_cmd;
    logic q_pop;

    assign cfg_ready = 1'b1;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable      <= 1'b0;
            cfg_reg.out_channel <= 2'd0;
            cfg_reg.period_ms   <= PERIOD_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_ENABLE:
                begin
                    cfg_reg.enable <= cfg_data[0];
                end
                CFG_CHANNEL:
                begin
                    cfg_reg.out_channel <= cfg_data[1:0];
                end
                CFG_PERIOD:
                begin
                    cfg_reg.period_ms <= cfg_data;
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // input classification and queue
    pgst_front #(
        .NUM_CIRCLES(NUM_CIRCLES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .q_pop         (q_pop)
    );

    // execution, table scan and result register
    pgst_back #(
        .NUM_CIRCLES  (NUM_CIRCLES),
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .q_pop         (q_pop),
        .cfg           (cfg_reg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

>>> tb/sv/tb_position_geofence_stim_trigger_unit.sv
// tb_position_geofence_stim_trigger_unit: self-checking bench for the geofence stim trigger
// drives position, tick and circle transfers, predicts each result and compares it field by field
// depends on pgst_pkg and position_geofence_stim_trigger_unit
module tb_position_geofence_stim_trigger_unit;

    import pgst_pkg::*;

    localparam int CIRCLES     = 8;
    localparam int CHANNELS    = 4;
    localparam int CLK_HALF    = 5;
    localparam int PHASE_ITEMS = 190;
    localparam int SETTLE      = 40;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_MAX   = 40;

    // one input item, fields as in the input transfer
    typedef struct packed {
        op_t         op;
        logic [15:0] x;
        logic [15:0] y;
        logic [2:0]  idx;
        logic [15:0] rad;
        logic        cv;
    } geo_item_t;

    // one row of the directed walk: either a register write or an item
    typedef struct {
        bit        is_reg;
        cfg_reg_t  reg_sel;
        logic [15:0] reg_val;
        geo_item_t item;
        bit        typed;
        out_t      want;
    } dir_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b1;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // predictor copy of the block state and registers
    logic [15:0] geo_px = '0;
    logic [15:0] geo_py = '0;
    bit          geo_known = 1'b0;
    logic [15:0] ring_cx [CIRCLES];
    logic [15:0] ring_cy [CIRCLES];
    logic [15:0] ring_r  [CIRCLES];
    bit          ring_on [CIRCLES];
    logic [15:0] ms_elapsed = ELAPSED_MAX;
    logic        arm_en = 1'b0;
    logic [1:0]  arm_chan = '0;
    logic [15:0] arm_period = PERIOD_RESET;

    out_t     pending_results [$];
    dir_row_t dir_rows [$];

    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int err_count      = 0;
    int n_items        = 0;
    int n_results      = 0;
    int n_fired        = 0;
    int n_inside       = 0;
    int n_reg_writes   = 0;
    int cycle_count    = 0;

    position_geofence_stim_trigger_unit #(
        .NUM_CIRCLES  (CIRCLES),
        .NUM_CHANNELS (CHANNELS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    always #(CLK_HALF) clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_results.size());
            $display("position_geofence_stim_trigger_unit: mismatch");
            $finish;
        end
    end

    // receiver backpressure
    always @(negedge clk)
    begin
        m_axis_tready <= (sink_stall_pct == 0) || ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // geofence predictor: apply one item, return the result it should produce
    function automatic out_t geofence_step(input geo_item_t it);
        out_t             res;
        logic [1:0]       chan;
        bit               hit;
        logic [2:0]       which;
        longint unsigned  dx, dy, rsq;
        int               i;
        res = '0;
        chan = (int'(arm_chan) >= CHANNELS) ? 2'(CHANNELS - 1) : arm_chan;
        // state update
        case (it.op)
            OP_POS:
                if (it.x != 0 && it.y != 0)
                begin
                    geo_px = it.x;
                    geo_py = it.y;
                    geo_known = 1'b1;
                end
            OP_CIRCLE:
                if (int'(it.idx) < CIRCLES)
                begin
                    if (it.cv)
                    begin
                        ring_cx[it.idx] = it.x;
                        ring_cy[it.idx] = it.y;
                        ring_r[it.idx]  = it.rad;
                    end
                    ring_on[it.idx] = it.cv;
                end
            default: ;
        endcase
        // point-in-circle scan, last match wins
        hit = 1'b0;
        which = '0;
        if (geo_known)
        begin
            for (i = 0; i < CIRCLES; i++)
            begin
                if (ring_on[i])
                begin
                    dx = (geo_px >= ring_cx[i]) ? (geo_px - ring_cx[i]) : (ring_cx[i] - geo_px);
                    dy = (geo_py >= ring_cy[i]) ? (geo_py - ring_cy[i]) : (ring_cy[i] - geo_py);
                    rsq = longint'(ring_r[i]) * longint'(ring_r[i]);
                    if (dx * dx + dy * dy <= rsq)
                    begin
                        hit = 1'b1;
                        which = 3'(i);
                    end
                end
            end
        end
        // tick: saturating counter and trigger decision
        if (it.op == OP_TICK)
        begin
            if (ms_elapsed != ELAPSED_MAX)
                ms_elapsed = ms_elapsed + 16'd1;
            if (arm_en && hit && ms_elapsed >= arm_period)
            begin
                res.trigger = 1'b1;
                ms_elapsed = '0;
            end
        end
        res.trigger_channel = chan;
        res.inside_res = hit;
        res.match_index = which;
        return res;
    endfunction

    // coordinate near a circle center, mostly within the radius
    function automatic logic [15:0] near_coord(input logic [15:0] c, input logic [15:0] r);
        int span, v;
        span = ($urandom_range(0, 9) < 7) ? int'(r) : 2 * int'(r);
        v = int'(c) + int'($urandom_range(0, span)) - span / 2;
        if (v < 1)
            v = 1;
        if (v > 65535)
            v = 65535;
        return 16'(v);
    endfunction

    // random item, shaped so points often land in stored circles
    function automatic geo_item_t make_stim_item();
        geo_item_t it;
        int sel, pick;
        it.x   = 16'($urandom);
        it.y   = 16'($urandom);
        it.idx = 3'($urandom);
        it.rad = 16'($urandom);
        it.cv  = 1'($urandom);
        sel = $urandom_range(0, 99);
        if (sel < 34)
            it.op = OP_TICK;
        else if (sel < 70)
        begin
            it.op = OP_POS;
            sel = $urandom_range(0, 99);
            pick = $urandom_range(0, CIRCLES - 1);
            if (sel < 7)
                it.x = '0;
            else if (sel < 14)
                it.y = '0;
            else if (sel < 18)
            begin
                it.x = '0;
                it.y = '0;
            end
            else if (sel < 85 && ring_on[pick])
            begin
                it.x = near_coord(ring_cx[pick], ring_r[pick]);
                it.y = near_coord(ring_cy[pick], ring_r[pick]);
            end
        end
        else if (sel < 95)
        begin
            it.op = OP_CIRCLE;
            it.cv = ($urandom_range(0, 99) < 85);
            sel = $urandom_range(0, 99);
            if (sel < 40)
                it.rad = 16'($urandom_range(16'h0400, 16'h4000));
            else if (sel < 50)
                it.rad = '0;
            else if (sel < 60)
                it.rad = 16'hFFFF;
            else if (sel < 75)
                it.rad = 16'($urandom_range(0, 255));
        end
        else
            it.op = OP_NONE;
        return it;
    endfunction

    // directed rows
    function automatic void dir_item(input op_t op, input logic [15:0] x, input logic [15:0] y,
                                     input logic [2:0] idx, input logic [15:0] rad,
                                     input logic cv);
        dir_row_t row;
        row.is_reg = 1'b0;
        row.reg_sel = CFG_ENABLE;
        row.reg_val = '0;
        row.item = '{op: op, x: x, y: y, idx: idx, rad: rad, cv: cv};
        row.typed = 1'b0;
        row.want = '0;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    function automatic void dir_check(input op_t op, input logic [15:0] x, input logic [15:0] y,
                                      input logic [2:0] idx, input logic [15:0] rad,
                                      input logic cv, input logic trig, input logic [1:0] chan,
                                      input logic ins, input logic [2:0] mi);
        dir_item(op, x, y, idx, rad, cv);
        dir_rows[$].typed = 1'b1;
        dir_rows[$].want = '{pad: 1'b0, match_index: mi, inside_res: ins,
                             trigger_channel: chan, trigger: trig};
    endfunction

    function automatic void dir_reg(input cfg_reg_t which, input logic [15:0] val);
        dir_row_t row;
        row.is_reg = 1'b1;
        row.reg_sel = which;
        row.reg_val = val;
        row.item = '0;
        row.typed = 1'b0;
        row.want = '0;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_count < PRINT_MAX)
            $display("ERROR result %0d %s: got %0d, want %0d", n_results, what, got, want);
        err_count++;
    endtask

    // result checker
    task automatic check_result(input out_t got);
        out_t want;
        n_results++;
        n_fired += got.trigger;
        n_inside += got.inside_res;
        if (pending_results.size() == 0)
        begin
            report_mismatch("with nothing pending", int'(got), 0);
            return;
        end
        want = pending_results.pop_front();
        if (got.trigger !== want.trigger)
            report_mismatch("trigger", got.trigger, want.trigger);
        if (got.trigger_channel !== want.trigger_channel)
            report_mismatch("trigger_channel", got.trigger_channel, want.trigger_channel);
        if (got.inside_res !== want.inside_res)
            report_mismatch("inside_res", got.inside_res, want.inside_res);
        if (got.match_index !== want.match_index)
            report_mismatch("match_index", got.match_index, want.match_index);
    endtask

    // output monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_result(out_t'(m_axis_tdata));
    end

    // register write transfer, called at a falling edge while idle
    task automatic write_reg(input cfg_reg_t which, input logic [15:0] val);
        cfg_valid = 1'b1;
        cfg_index = which;
        cfg_data = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (which)
            CFG_ENABLE:  arm_en = val[0];
            CFG_CHANNEL: arm_chan = val[1:0];
            CFG_PERIOD:  arm_period = val;
            default: ;
        endcase
        n_reg_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // input transfer, called at a falling edge
    task automatic send_item(input geo_item_t it, input bit typed, input out_t want);
        out_t pred;
        while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {4'b0000, it.cv, it.rad, it.idx, it.y, it.x};
        s_axis_tuser = it.op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pred = geofence_step(it);
        pending_results.insert(pending_results.size(), typed ? want : pred);
        n_items++;
        @(negedge clk);
    endtask

    // hold the sender until every pending result has come back
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        int k, ph, n;

        // directed rows, reset settings first
        dir_check(OP_TICK,   16'h0000, 16'h0000, 3'd0, 16'h0000, 1'b0, 1'b0, 2'd0, 1'b0, 3'd0);
        dir_check(OP_POS,    16'h0000, 16'h0005, 3'd0, 16'h0000, 1'b0, 1'b0, 2'd0, 1'b0, 3'd0);
        dir_check(OP_CIRCLE, 16'hFFFF, 16'hFFFF, 3'd7, 16'hFFFF, 1'b1, 1'b0, 2'd0, 1'b0, 3'd0);
        dir_check(OP_POS,    16'hFFFF, 16'hFFFF, 3'd0, 16'h0000, 1'b0, 1'b0, 2'd0, 1'b1, 3'd7);
        dir_check(OP_TICK,   16'h0000, 16'h0000, 3'd0, 16'h0000, 1'b0, 1'b0, 2'd0, 1'b1, 3'd7);
        dir_check(OP_NONE,   16'hFFFF, 16'hFFFF, 3'd7, 16'hFFFF, 1'b1, 1'b0, 2'd0, 1'b1, 3'd7);
        // armed, widest period: saturated counter still fires once
        dir_reg(CFG_ENABLE, 16'd1);
        dir_reg(CFG_CHANNEL, 16'd3);
        dir_reg(CFG_PERIOD, 16'hFFFF);
        dir_check(OP_TICK,   16'h0000, 16'h0000, 3'd0, 16'h0000, 1'b0, 1'b1, 2'd3, 1'b1, 3'd7);
        dir_check(OP_TICK,   16'h0000, 16'h0000, 3'd0, 16'h0000, 1'b0, 1'b0, 2'd3, 1'b1, 3'd7);
        // zero period fires on every qualifying tick
        dir_reg(CFG_PERIOD, 16'd0);
        dir_check(OP_TICK,   16'h0000, 16'h0000, 3'd0, 16'h0000, 1'b0, 1'b1, 2'd3, 1'b1, 3'd7);
        dir_check(OP_CIRCLE, 16'h0001, 16'h0001, 3'd0, 16'h0000, 1'b1, 1'b0, 2'd3, 1'b1, 3'd7);
        dir_check(OP_POS,    16'h0001, 16'h0001, 3'd0, 16'h0000, 1'b0, 1'b0, 2'd3, 1'b1, 3'd0);
        // delete only clears the valid bit
        dir_check(OP_CIRCLE, 16'h1234, 16'h4321, 3'd0, 16'h5555, 1'b0, 1'b0, 2'd3, 1'b0, 3'd0);
        dir_check(OP_TICK,   16'h0000, 16'h0000, 3'd0, 16'h0000, 1'b0, 1'b0, 2'd3, 1'b0, 3'd0);
        dir_item(OP_CIRCLE, 16'h8000, 16'h8000, 3'd3, 16'hFFFF, 1'b1);
        dir_item(OP_TICK,   16'hAAAA, 16'h5555, 3'd5, 16'hAAAA, 1'b1);
        dir_item(OP_POS,    16'h8000, 16'h0000, 3'd2, 16'h0001, 1'b0);
        dir_item(OP_POS,    16'h0000, 16'h0000, 3'd2, 16'h0001, 1'b0);
        dir_item(OP_POS,    16'hFFFF, 16'h0001, 3'd1, 16'h0000, 1'b1);
        dir_item(OP_CIRCLE, 16'hFFF0, 16'h0010, 3'd5, 16'h0020, 1'b1);
        dir_item(OP_TICK,   16'h0000, 16'h0000, 3'd0, 16'h0000, 1'b0);
        // disabled: counter runs, nothing fires
        dir_reg(CFG_ENABLE, 16'd0);
        dir_reg(CFG_CHANNEL, 16'd0);
        dir_item(OP_TICK,   16'hFFFF, 16'hFFFF, 3'd7, 16'hFFFF, 1'b1);
        dir_item(OP_NONE,   16'h0000, 16'h0000, 3'd0, 16'h0000, 1'b0);

        // reset
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed walk
        for (k = 0; k < dir_rows.size(); k++)
        begin
            if (dir_rows[k].is_reg)
            begin
                drain();
                write_reg(dir_rows[k].reg_sel, dir_rows[k].reg_val);
            end
            else
                send_item(dir_rows[k].item, dir_rows[k].typed, dir_rows[k].want);
        end
        drain();

        // random phases with different handshake pressure and settings
        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    src_idle_pct = 0;
                    sink_stall_pct = 0;
                    write_reg(CFG_ENABLE, 16'd1);
                    write_reg(CFG_CHANNEL, 16'd0);
                    write_reg(CFG_PERIOD, 16'd1);
                end
                1:
                begin
                    src_idle_pct = 49;
                    sink_stall_pct = 0;
                    write_reg(CFG_CHANNEL, 16'd2);
                    write_reg(CFG_PERIOD, 16'($urandom_range(2, 15)));
                end
                2:
                begin
                    src_idle_pct = 0;
                    sink_stall_pct = 49;
                    write_reg(CFG_ENABLE, 16'd0);
                    write_reg(CFG_CHANNEL, 16'd1);
                end
                default:
                begin
                    src_idle_pct = 19;
                    sink_stall_pct = 19;
                    write_reg(CFG_ENABLE, 16'd1);
                    write_reg(CFG_CHANNEL, 16'd3);
                    write_reg(CFG_PERIOD, 16'($urandom_range(1, 40)));
                end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // sender holds off once until the block has caught up
                if (ph == 1 && n == PHASE_ITEMS / 2)
                    drain();
                send_item(make_stim_item(), 1'b0, '0);
            end
            drain();
        end

        // let any stray result show up
        sink_stall_pct = 0;
        repeat (SETTLE) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("never returned", pending_results.size(), 0);

        $display("run covered %0d items (directed, then four handshake phases), %0d register writes",
                 n_items, n_reg_writes);
        $display("%0d results checked, %0d triggers fired, %0d with the point inside a circle",
                 n_results, n_fired, n_inside);
        if (err_count == 0)
            $display("position_geofence_stim_trigger_unit: match");
        else
            $display("position_geofence_stim_trigger_unit: mismatch");
        $finish;
    end

endmodule

>>> files.f
rtl/pgst_pkg.sv
rtl/pgst_front.sv
rtl/pgst_back.sv
rtl/position_geofence_stim_trigger_unit.sv
tb/sv/tb_position_geofence_stim_trigger_unit.sv
